// ----- sv/rbal_pkg.sv -----
// ----------------------------------------------------------------------------
// rbal_pkg
// Shared types, codes and constants of the per-link RSSI block averager.
// ----------------------------------------------------------------------------
package rbal_pkg;

    // number of links with their own accumulator
    localparam int NUM_LINKS = 4;
    localparam int LINK_AW   = $clog2(NUM_LINKS);

    // negated average sum, wide enough for NUM_LINKS * 128
    localparam int ACC_W = 9 + LINK_AW;
    // compare width that also holds a 10-bit level unsigned
    localparam int CMP_W = ACC_W + 2;

    // divider: one quotient bit per cycle over the 16-bit sum
    localparam int DIV_STEPS = 16;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    // action codes
    localparam logic [1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [1:0] ACT_RESTART  = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;

    // result kinds
    localparam logic KIND_AVERAGE = 1'b0;
    localparam logic KIND_LEVEL   = 1'b1;

    // register indexes
    localparam logic [1:0] REG_WINDOW_LIMIT = 2'd0;
    localparam logic [1:0] REG_HIGH_LEVEL   = 2'd1;
    localparam logic [1:0] REG_MID_LEVEL    = 2'd2;

    // register reset values
    localparam logic [6:0] WINDOW_LIMIT_RST = 7'd50;
    localparam logic [9:0] HIGH_LEVEL_RST   = 10'd80;
    localparam logic [9:0] MID_LEVEL_RST    = 10'd70;

    // led drive values
    localparam logic [7:0] LED_OFF          = 8'd0;
    localparam logic [7:0] LED_FULL         = 8'd255;
    localparam logic [7:0] LED_ORANGE_RED   = 8'd153;
    localparam logic [7:0] LED_ORANGE_GREEN = 8'd76;

    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        link_index;
        logic signed [7:0] rssi_dbm;
        logic              link_connected;
    } req_t;

    typedef struct packed {
        logic              result_kind;
        logic [1:0]        link_out;
        logic signed [7:0] average_dbm;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } rsp_t;

    typedef struct packed {
        logic [6:0] window_limit;
        logic [9:0] high_level;
        logic [9:0] mid_level;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic acc_write;
        logic restart_clear;
        logic div_start;
        logic avg_write;
        logic sum_clear;
        logic sum_step;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       link_ok;
        logic       connected;
        logic       window_over;
        logic       div_done;
        logic       last_link;
        logic       out_free;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD,
        ST_DIVIDE,
        ST_SUM,
        ST_EMIT
    } state_t;

endpackage

// ----- sv/rbal_div.sv -----
// ----------------------------------------------------------------------------
// rbal_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module rbal_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic signed [15:0] dividend,
    input  logic [7:0]        divisor,
    output logic              done,
    output logic signed [7:0] quotient
);
    import rbal_pkg::*;

    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [7:0]        rem_reg, rem_next;
    logic [15:0]       quo_reg, quo_next;
    logic [7:0]        div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [8:0]        rem_shift;
    logic              fits;

    // one restoring step
    assign rem_shift = {rem_reg, quo_reg[15]};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            cnt_next = DIV_CW'(DIV_STEPS);
            rem_next = '0;
            quo_next = dividend[15] ? 16'(-dividend) : 16'(dividend);
            div_next = divisor;
            neg_next = dividend[15];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CW'(1));
            rem_next  = fits ? 8'(rem_shift - {1'b0, div_reg}) : rem_shift[7:0];
            quo_next  = {quo_reg[14:0], fits};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // magnitude is at most 128, so the low byte carries the signed result
    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(8'(-quo_reg[7:0])) : $signed(quo_reg[7:0]);

endmodule

// ----- sv/rbal_dp.sv -----
// ----------------------------------------------------------------------------
// rbal_dp
// Datapath: per-link accumulators, averages, level sum and result register.
// ----------------------------------------------------------------------------
module rbal_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbal_pkg::cfg_t       cfg,
    input  rbal_pkg::req_t       req,
    input  rbal_pkg::dp_cmd_t    cmd,
    output rbal_pkg::dp_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rbal_pkg::rsp_t       rsp
);
    import rbal_pkg::*;

    req_t              item_reg;
    logic [7:0]        count_reg [NUM_LINKS];
    logic [7:0]        count_next [NUM_LINKS];
    logic signed [15:0] sum_reg [NUM_LINKS];
    logic signed [15:0] sum_next [NUM_LINKS];
    logic signed [7:0] avg_reg [NUM_LINKS];
    logic signed [7:0] avg_next [NUM_LINKS];
    logic [LINK_AW-1:0] idx_reg, idx_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [LINK_AW-1:0] sel;
    logic [7:0]        count_inc;
    logic signed [15:0] sum_inc;
    logic              window_over;
    logic              div_done;
    logic signed [7:0] quotient;
    logic signed [CMP_W-1:0] level;
    logic signed [CMP_W-1:0] high_ext;
    logic signed [CMP_W-1:0] mid_ext;
    logic [7:0]        red;
    logic [7:0]        green;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
    end

    assign sel       = LINK_AW'(item_reg.link_index);
    assign count_inc = count_reg[sel] + 8'd1;
    assign sum_inc   = sum_reg[sel] + 16'(item_reg.rssi_dbm);
    assign window_over = count_inc > {1'b0, cfg.window_limit};

    rbal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_inc),
        .divisor  (count_inc),
        .done     (div_done),
        .quotient (quotient)
    );

    // accumulator and average updates
    always_comb
    begin
        for (int i = 0; i < NUM_LINKS; i++)
        begin
            count_next[i] = count_reg[i];
            sum_next[i]   = sum_reg[i];
            avg_next[i]   = avg_reg[i];
        end
        if (cmd.acc_write)
        begin
            count_next[sel] = window_over ? 8'd0 : count_inc;
            sum_next[sel]   = window_over ? 16'sd0 : sum_inc;
        end
        if (cmd.restart_clear)
        begin
            count_next[sel] = 8'd0;
            sum_next[sel]   = 16'sd0;
        end
        if (cmd.avg_write)
        begin
            avg_next[sel] = quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINKS; i++)
            begin
                count_reg[i] <= '0;
                sum_reg[i]   <= '0;
                avg_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LINKS; i++)
            begin
                count_reg[i] <= count_next[i];
                sum_reg[i]   <= sum_next[i];
                avg_reg[i]   <= avg_next[i];
            end
        end
    end

    // serial sum of negated averages, one link per cycle
    always_comb
    begin
        idx_next = idx_reg;
        acc_next = acc_reg;
        if (cmd.sum_clear)
        begin
            idx_next = '0;
            acc_next = '0;
        end
        else if (cmd.sum_step)
        begin
            idx_next = idx_reg + 1'b1;
            acc_next = acc_reg - ACC_W'(avg_reg[idx_reg]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // level classification
    assign level    = CMP_W'(acc_reg);
    assign high_ext = $signed(CMP_W'(cfg.high_level));
    assign mid_ext  = $signed(CMP_W'(cfg.mid_level));

    always_comb
    begin
        if (level == '0)
        begin
            red   = LED_OFF;
            green = LED_OFF;
        end
        else if (level >= high_ext)
        begin
            red   = LED_FULL;
            green = LED_OFF;
        end
        else if (level >= mid_ext)
        begin
            red   = LED_ORANGE_RED;
            green = LED_ORANGE_GREEN;
        end
        else
        begin
            red   = LED_OFF;
            green = LED_FULL;
        end
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (item_reg.action == ACT_CLASSIFY)
            begin
                out_next.result_kind = KIND_LEVEL;
                out_next.link_out    = '0;
                out_next.average_dbm = '0;
                out_next.red         = red;
                out_next.green       = green;
            end
            else
            begin
                out_next.result_kind = KIND_AVERAGE;
                out_next.link_out    = item_reg.link_index;
                out_next.average_dbm = quotient;
                out_next.red         = LED_OFF;
                out_next.green       = LED_OFF;
            end
            out_next.blue = LED_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // status to controller
    assign status.action      = item_reg.action;
    assign status.link_ok     = int'(item_reg.link_index) < NUM_LINKS;
    assign status.connected   = item_reg.link_connected;
    assign status.window_over = window_over;
    assign status.div_done    = div_done;
    assign status.last_link   = idx_reg == LINK_AW'(NUM_LINKS - 1);
    assign status.out_free    = !out_valid_reg || rsp_ready;

endmodule

// ----- sv/rbal_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbal_ctrl
// Controller: sequences decode, accumulate, divide, level sum and emit.
// ----------------------------------------------------------------------------
module rbal_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  rbal_pkg::dp_status_t status,
    output rbal_pkg::dp_cmd_t    cmd
);
    import rbal_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.action)
                    ACT_SAMPLE:   state_next = status.link_ok ? ST_ADD : ST_IDLE;
                    ACT_CLASSIFY: state_next = ST_SUM;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_ADD:
            begin
                state_next = status.window_over ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SUM:
            begin
                if (status.last_link)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_DECODE:
            begin
                cmd.restart_clear = (status.action == ACT_RESTART)
                                    && status.link_ok && status.connected;
                cmd.sum_clear     = (status.action == ACT_CLASSIFY);
            end
            ST_ADD:
            begin
                cmd.acc_write = 1'b1;
                cmd.div_start = status.window_over;
            end
            ST_DIVIDE:
            begin
                cmd.avg_write = status.div_done;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/rssi_block_average_led_level.sv -----
// A sample that closes its window gives its average after decode, accumulate, the
// bit-serial divider and emit; a classify result follows decode, the level sum,
// one link average summed per cycle, and emit, which waits while an earlier
// result is untaken. One transaction is in work at a time; the output register
// lets the next transaction be accepted while a result waits.
// Reset clears the accumulators, the averages and the registers to their defaults.
// ----------------------------------------------------------------------------
// rssi_block_average_led_level
// Per-link RSSI window averager with a three-color level indicator.
// ----------------------------------------------------------------------------
module rssi_block_average_led_level (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  rbal_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output rbal_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import rbal_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       wr_en;
    logic [1:0] reg_idx;

    // register file
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_WINDOW_LIMIT: cfg_next.window_limit = pwdata[6:0];
                REG_HIGH_LEVEL:   cfg_next.high_level   = pwdata[9:0];
                REG_MID_LEVEL:    cfg_next.mid_level    = pwdata[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_limit <= WINDOW_LIMIT_RST;
            cfg_reg.high_level   <= HIGH_LEVEL_RST;
            cfg_reg.mid_level    <= MID_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW_LIMIT: prdata = {25'd0, cfg_reg.window_limit};
            REG_HIGH_LEVEL:   prdata = {22'd0, cfg_reg.high_level};
            REG_MID_LEVEL:    prdata = {22'd0, cfg_reg.mid_level};
            default:          prdata = '0;
        endcase
    end

    rbal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rbal_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
